// ===== rtl/cdsw_pkg.sv =====
// ----------------------------------------------------------------------------
// cdsw_pkg: shared types, constants and calendar functions
// Beat formats, operation codes and the small calendar tables used by the
// date step and weekday pipeline.
// ----------------------------------------------------------------------------
package cdsw_pkg;

	localparam logic [1:0] OP_ADD_DAY    = 2'd0;
	localparam logic [1:0] OP_ADD_MONTH  = 2'd1;
	localparam logic [1:0] OP_ADD_YEAR   = 2'd2;
	localparam logic [1:0] OP_NEXT_MONDAY = 2'd3;

	localparam logic [13:0] YEAR_MIN = 14'd1970;
	localparam logic [13:0] YEAR_MAX = 14'd9999;

	// floor(x / 100) == (x * 5243) >> 19 for every 14-bit x.
	localparam logic [12:0] RECIP_100       = 13'd5243;
	localparam int unsigned RECIP_100_SHIFT = 19;
	// floor(x / 7) == (x * 18726) >> 17 for every x below 13110.
	localparam logic [14:0] RECIP_7         = 15'd18726;
	localparam int unsigned RECIP_7_SHIFT   = 17;

	typedef struct packed {
		logic [1:0]  operation;
		logic [13:0] in_year;
		logic [3:0]  in_month;
		logic [4:0]  in_day;
	} cmd_t;

	typedef struct packed {
		logic [13:0] out_year;
		logic [3:0]  out_month;
		logic [4:0]  out_day;
		logic [2:0]  weekday;
		logic        error;
	} res_t;

	// Front end to weekday stages.
	typedef struct packed {
		cmd_t        cmd;
		logic        leap;
		logic        ok;
		logic [14:0] wsum;
	} front_t;

	// Weekday stages to date step stage.
	typedef struct packed {
		cmd_t       cmd;
		logic       leap;
		logic       ok;
		logic [2:0] wd;
		logic [2:0] delta;
	} wkd_t;

	function automatic logic [2:0] month_offset(input logic [3:0] m);
		logic [2:0] r;
		unique case (m)
			4'd1:    r = 3'd0;
			4'd2:    r = 3'd3;
			4'd3:    r = 3'd2;
			4'd4:    r = 3'd5;
			4'd5:    r = 3'd0;
			4'd6:    r = 3'd3;
			4'd7:    r = 3'd5;
			4'd8:    r = 3'd1;
			4'd9:    r = 3'd4;
			4'd10:   r = 3'd6;
			4'd11:   r = 3'd2;
			4'd12:   r = 3'd4;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] r;
		unique case (m)
			4'd2:                      r = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
			default:                   r = 5'd31;
		endcase
		return r;
	endfunction

	// Days to the next Monday; a Monday moves a full week.
	function automatic logic [2:0] monday_delta(input logic [2:0] wd);
		logic [2:0] r;
		unique case (wd)
			3'd0:    r = 3'd1;
			3'd1:    r = 3'd7;
			3'd2:    r = 3'd6;
			3'd3:    r = 3'd5;
			3'd4:    r = 3'd4;
			3'd5:    r = 3'd3;
			3'd6:    r = 3'd2;
			default: r = 3'd1;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/calendar_date_step_and_weekday_unit.sv =====
// ----------------------------------------------------------------------------
// calendar_date_step_and_weekday_unit: Gregorian date step and weekday
// Steps a date by a day, a month, a year or to the next Monday, and gives
// the weekday of the input date, in a five-stage pipeline.
//
//   channel   beat              handshake             direction
//   command   cmd (cmd_t)       start && !busy        in
//   result    res (res_t)       done, one cycle       out
//
// One command beat is taken every cycle; busy stays low.
// Each result leaves stage 5 in command order.
// The two reciprocal multiplications (by 1/100 and 1/7) each own a stage.
// Reset clears the stage valid bits only; no clearing pass is needed.
// The receiver cannot stall, so nothing holds the pipeline.
// ----------------------------------------------------------------------------
module calendar_date_step_and_weekday_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  cdsw_pkg::cmd_t  cmd,
	output logic            busy,
	output logic            done,
	output cdsw_pkg::res_t  res
);
	import cdsw_pkg::*;

	logic   valid_s2;
	front_t fr_s2;
	logic   valid_s4;
	wkd_t   wk_s4;

	assign busy = 1'b0;

	cdsw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.cmd      (cmd),
		.valid_s2 (valid_s2),
		.fr_s2    (fr_s2)
	);

	cdsw_weekday u_weekday (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.fr_s2    (fr_s2),
		.valid_s4 (valid_s4),
		.wk_s4    (wk_s4)
	);

	cdsw_step u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s4 (valid_s4),
		.wk_s4    (wk_s4),
		.done     (done),
		.res      (res)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 5))
		else $error("result beat without a command five cycles before");

	a_echo_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.error |-> res.out_year == $past(cmd.in_year, 5) &&
		res.out_month == $past(cmd.in_month, 5) && res.out_day == $past(cmd.in_day, 5))
		else $error("error result does not echo the command date");

	a_year_step: assert property (@(posedge clk) disable iff (!arst_n)
		done && !res.error |-> res.out_year == $past(cmd.in_year, 5) ||
		res.out_year == $past(cmd.in_year, 5) + 14'd1)
		else $error("result year moved by more than one");

endmodule

// ===== rtl/cdsw_front.sv =====
// ----------------------------------------------------------------------------
// cdsw_front: input stages
// Stage 1 divides the year by 100 by reciprocal multiplication. Stage 2
// derives the leap flag, checks the date and forms the weekday sum.
// ----------------------------------------------------------------------------
module cdsw_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  cdsw_pkg::cmd_t    cmd,
	output logic              valid_s2,
	output cdsw_pkg::front_t  fr_s2
);
	import cdsw_pkg::*;

	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [13:0] yy_s1;
	logic [7:0]  q100y_s1;
	logic [7:0]  q100yy_s1;

	logic [13:0] yy;
	logic [26:0] prod_y;
	logic [26:0] prod_yy;

	// Years of January and February count with the previous year.
	assign yy      = (cmd.in_month < 4'd3) ? cmd.in_year - 14'd1 : cmd.in_year;
	assign prod_y  = 27'(cmd.in_year) * 27'(RECIP_100);
	assign prod_yy = 27'(yy) * 27'(RECIP_100);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			cmd_s1    <= cmd;
			yy_s1     <= yy;
			q100y_s1  <= prod_y[RECIP_100_SHIFT +: 8];
			q100yy_s1 <= prod_yy[RECIP_100_SHIFT +: 8];
		end
	end

	logic       leap;
	logic       div100;
	logic [4:0] mlen;
	logic       ok;
	logic [14:0] wsum;

	always_comb begin
		div100 = (15'(cmd_s1.in_year) == 15'(q100y_s1) * 15'd100);
		leap   = (cmd_s1.in_year[1:0] == 2'd0) && (!div100 || (q100y_s1[1:0] == 2'd0));
		mlen   = month_len(cmd_s1.in_month, leap);
		ok     = (cmd_s1.in_year >= YEAR_MIN) && (cmd_s1.in_year <= YEAR_MAX) &&
		         (cmd_s1.in_month >= 4'd1) && (cmd_s1.in_month <= 4'd12) &&
		         (cmd_s1.in_day >= 5'd1) && (cmd_s1.in_day <= mlen);
		wsum   = 15'(yy_s1) + 15'(yy_s1[13:2]) - 15'(q100yy_s1) + 15'(q100yy_s1[7:2]) +
		         15'(month_offset(cmd_s1.in_month)) + 15'(cmd_s1.in_day);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			fr_s2.cmd  <= cmd_s1;
			fr_s2.leap <= leap;
			fr_s2.ok   <= ok;
			fr_s2.wsum <= wsum;
		end
	end

endmodule

// ===== rtl/cdsw_weekday.sv =====
// ----------------------------------------------------------------------------
// cdsw_weekday: weekday stages
// Stage 3 divides the weekday sum by 7 through a reciprocal product. Stage 4
// takes the remainder and the day step: one for OP_ADD_DAY, else the distance to the next Monday.
// ----------------------------------------------------------------------------
module cdsw_weekday (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s2,
	input  cdsw_pkg::front_t  fr_s2,
	output logic              valid_s4,
	output cdsw_pkg::wkd_t    wk_s4
);
	import cdsw_pkg::*;

	logic        valid_s3;
	front_t      fr_s3;
	logic [12:0] q7_s3;
	logic [29:0] prod7;

	assign prod7 = 30'(fr_s2.wsum) * 30'(RECIP_7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			fr_s3 <= fr_s2;
			q7_s3 <= prod7[RECIP_7_SHIFT +: 13];
		end
	end

	logic [14:0] rem;
	logic [2:0]  wd;

	assign rem = fr_s3.wsum - 15'(q7_s3) * 15'd7;
	assign wd  = rem[2:0];

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			wk_s4.cmd   <= fr_s3.cmd;
			wk_s4.leap  <= fr_s3.leap;
			wk_s4.ok    <= fr_s3.ok;
			wk_s4.wd    <= wd;
			wk_s4.delta <= (fr_s3.cmd.operation == OP_ADD_DAY) ? 3'd1 : monday_delta(wd);
		end
	end

endmodule

// ===== rtl/cdsw_step.sv =====
// ----------------------------------------------------------------------------
// cdsw_step: date step and result register
// Stage 5 applies the operation, checks the year limit and registers the
// result beat with its strobe.
// ----------------------------------------------------------------------------
module cdsw_step (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s4,
	input  cdsw_pkg::wkd_t  wk_s4,
	output logic            done,
	output cdsw_pkg::res_t  res
);
	import cdsw_pkg::*;

	logic [13:0] y;
	logic [3:0]  m;
	logic [4:0]  d;
	logic [13:0] ny;
	logic [3:0]  nm;
	logic [4:0]  nd;
	logic [4:0]  mlen;
	logic [4:0]  len2;
	logic [5:0]  dsum;
	logic [3:0]  m_next;
	res_t        res_d;

	always_comb begin
		y      = wk_s4.cmd.in_year;
		m      = wk_s4.cmd.in_month;
		d      = wk_s4.cmd.in_day;
		mlen   = month_len(m, wk_s4.leap);
		dsum   = 6'(d) + 6'(wk_s4.delta);
		m_next = (m == 4'd12) ? 4'd1 : m + 4'd1;
		len2   = month_len(m_next, wk_s4.leap);
		ny     = y;
		nm     = m;
		nd     = d;
		unique case (wk_s4.cmd.operation)
			OP_ADD_DAY, OP_NEXT_MONDAY: begin
				// A step of at most a week crosses at most one month end.
				if (dsum <= 6'(mlen)) begin
					nd = dsum[4:0];
				end else begin
					nd = 5'(dsum - 6'(mlen));
					nm = m_next;
					if (m == 4'd12) begin
						ny = y + 14'd1;
					end
				end
			end
			OP_ADD_MONTH: begin
				nm = m_next;
				if (m == 4'd12) begin
					ny = y + 14'd1;
				end
				nd = (d > len2) ? len2 : d;
			end
			OP_ADD_YEAR: begin
				ny = y + 14'd1;
				if (m == 4'd2 && d == 5'd29) begin
					nd = 5'd28;
				end
			end
		endcase

		if (!wk_s4.ok || ny > YEAR_MAX) begin
			res_d.out_year  = y;
			res_d.out_month = m;
			res_d.out_day   = d;
			res_d.weekday   = 3'd0;
			res_d.error     = 1'b1;
		end else begin
			res_d.out_year  = ny;
			res_d.out_month = nm;
			res_d.out_day   = nd;
			res_d.weekday   = wk_s4.wd;
			res_d.error     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s4) begin
			res <= res_d;
		end
	end

	a_date_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && !res.error |-> res.out_month >= 4'd1 && res.out_month <= 4'd12 &&
		res.out_day >= 5'd1 && res.out_year >= YEAR_MIN && res.out_year <= YEAR_MAX)
		else $error("stepped date out of range");

	a_error_weekday: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.error |-> res.weekday == 3'd0)
		else $error("weekday not cleared on error");

	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> res.weekday <= 3'd6)
		else $error("weekday out of range");

endmodule
